// File: hw/rtl/rgbhsl_pkg.sv
// Shared types and constants for the RGB to HSL converter.
// Used by the pipelined divider and the converter top level; no dependencies.
`default_nettype none

package rgbhsl_pkg;

  localparam int COMP_W = 8;   // width of one color component
  localparam int HUE_W  = 15;  // hue in 1/64 degree
  localparam int FRAC_W = 16;  // saturation and lightness scaled by 65535

  // Divider geometry: numerators below 2^24, 8-bit divisors, 16 quotient bits,
  // one quotient bit per stage plus one rounding stage.
  localparam int DIV_NUM_W = 24;
  localparam int DIV_DEN_W = 8;
  localparam int DIV_Q_W   = 16;
  localparam int DIV_LAT   = DIV_Q_W + 1;

  // Sum of max and min at which the saturation divisor switches over,
  // and the full-scale sum.
  localparam int SUM_HALF = 255;
  localparam int SUM_FULL = 510;

  // Sector offsets in units of 60 degrees.
  localparam int HUE_OFF_RED_WRAP = 6;
  localparam int HUE_OFF_GREEN    = 2;
  localparam int HUE_OFF_BLUE     = 4;

  // One full turn of hue in 1/64 degree.
  localparam int HUE_FULL_TURN = 23040;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } rgb_pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [FRAC_W-1:0] saturation;
    logic [FRAC_W-1:0] lightness;
  } hsl_pixel_t;

endpackage

`default_nettype wire

// File: hw/rtl/rgbhsl_div.sv
// Pipelined restoring divider with round-to-nearest (half up) quotient.
// One quotient bit per register stage, then a rounding stage; uses rgbhsl_pkg.
`default_nettype none

module rgbhsl_div import rgbhsl_pkg::*; #(
  parameter int NUM_W = DIV_NUM_W,
  parameter int DEN_W = DIV_DEN_W,
  parameter int Q_W   = DIV_Q_W
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quot
);

  // The quotient must fit in Q_W bits: num < den * 2^Q_W.
  localparam int CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [CMP_W-1:0] rem_r [1:Q_W];
  logic [DEN_W-1:0] den_r [1:Q_W];
  logic [Q_W-1:0]   q_r   [1:Q_W];
  logic [Q_W-1:0]   quot_r;
  logic [CMP_W:0]   twice_rem;
  logic             round_up;

  genvar i;
  for (i = 0; i < Q_W; i++) begin : g_stage
    logic [CMP_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   q_in;
    logic [CMP_W-1:0] trial;
    logic [CMP_W:0]   diff;

    if (i == 0) begin : g_first
      assign rem_in = CMP_W'(num);
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[i];
      assign den_in = den_r[i];
      assign q_in   = q_r[i];
    end

    // Trial subtract of the divisor aligned to this quotient bit.
    assign trial = CMP_W'(den_in) << (Q_W - 1 - i);
    assign diff  = {1'b0, rem_in} - {1'b0, trial};

    always_ff @(posedge clk) begin
      rem_r[i+1] <= diff[CMP_W] ? rem_in : diff[CMP_W-1:0];
      den_r[i+1] <= den_in;
      q_r[i+1]   <= {q_in[Q_W-2:0], ~diff[CMP_W]};
    end
  end

  // Round up when the remainder is at least half the divisor.
  assign twice_rem = {rem_r[Q_W], 1'b0};
  assign round_up  = twice_rem >= (CMP_W + 1)'(den_r[Q_W]);

  always_ff @(posedge clk) begin
    quot_r <= q_r[Q_W] + Q_W'(round_up);
  end

  assign quot = quot_r;

endmodule

`default_nettype wire

// File: hw/rtl/rgb_to_hsl_converter.sv
// RGB to HSL converter: a request passes through two front-end stages, 17
// divider stages and one output stage, the first loading at the accepting
// edge, before the result strobe rises. Throughput is one request per clock;
// busy is never raised and the result strobe cannot be held off, so every
// stage advances on every clock.
// Synchronous active-low reset clears only the valid bits of the pipeline;
// data registers are not reset. Depends on rgbhsl_pkg and rgbhsl_div.
`default_nettype none

module rgb_to_hsl_converter import rgbhsl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  rgb_pixel_t in_data,
  output logic       out_valid,
  output hsl_pixel_t out_data
);

  localparam int PIPE_LAT = DIV_LAT + 3;

  // The pipeline never stalls, so a request is taken whenever start is high.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Stage 1: find max and min, pick the hue sector, and form the component
  // difference that goes with it. Ties resolve red, then green, then blue.
  // ---------------------------------------------------------------------------
  logic [COMP_W-1:0]       mx, mn;
  sector_t                 sector;
  logic signed [COMP_W:0]  diff;

  logic                    s1_valid_r;
  sector_t                 s1_sector_r;
  logic [COMP_W-1:0]       s1_d_r;
  logic [COMP_W:0]         s1_sum_r;
  logic signed [COMP_W:0]  s1_diff_r;

  always_comb begin
    if (in_data.red >= in_data.green && in_data.red >= in_data.blue) begin
      sector = SEC_RED;
      mx     = in_data.red;
    end else if (in_data.green >= in_data.blue) begin
      sector = SEC_GREEN;
      mx     = in_data.green;
    end else begin
      sector = SEC_BLUE;
      mx     = in_data.blue;
    end

    mn = in_data.red;
    if (in_data.green < mn) begin
      mn = in_data.green;
    end
    if (in_data.blue < mn) begin
      mn = in_data.blue;
    end

    case (sector)
      SEC_RED: begin
        diff = $signed({1'b0, in_data.green}) - $signed({1'b0, in_data.blue});
      end
      SEC_GREEN: begin
        diff = $signed({1'b0, in_data.blue}) - $signed({1'b0, in_data.red});
      end
      SEC_BLUE: begin
        diff = $signed({1'b0, in_data.red}) - $signed({1'b0, in_data.green});
      end
      default: begin
        diff = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
    s1_sector_r <= sector;
    s1_d_r      <= mx - mn;
    s1_sum_r    <= {1'b0, mx} + {1'b0, mn};
    s1_diff_r   <= diff;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: build the divider operands and the lightness.
  // Hue numerator is 3840 * (offset * d + diff), where the offset is the
  // sector start in units of 60 degrees; a negative red-sector difference
  // wraps by a full turn. Saturation numerator is d * 65535 over the sum or
  // its complement to 510. Lightness is sum * 65535 / 510 = sum * 257 / 2,
  // so rounding half up is just adding one before the halving.
  // A gray pixel gets a divisor of one so the divider stays well defined;
  // its hue and saturation are forced to zero at the output.
  // ---------------------------------------------------------------------------
  logic                    gray;
  logic [2:0]              sec_off;
  logic [10:0]             sec_base;
  logic signed [11:0]      hue_k_s;
  logic [10:0]             hue_k;
  logic [DIV_NUM_W-1:0]    hue_num;
  logic [DIV_NUM_W-1:0]    sat_num;
  logic [DIV_DEN_W-1:0]    hue_den;
  logic [DIV_DEN_W-1:0]    sat_den;
  logic [FRAC_W:0]         lit_x2;

  logic                    s2_valid_r;
  logic                    s2_gray_r;
  logic [DIV_NUM_W-1:0]    s2_hue_num_r;
  logic [DIV_NUM_W-1:0]    s2_sat_num_r;
  logic [DIV_DEN_W-1:0]    s2_hue_den_r;
  logic [DIV_DEN_W-1:0]    s2_sat_den_r;
  logic [FRAC_W-1:0]       s2_lit_r;

  always_comb begin
    gray = (s1_d_r == '0);

    case (s1_sector_r)
      SEC_RED:   sec_off = s1_diff_r[COMP_W] ? 3'(HUE_OFF_RED_WRAP) : 3'd0;
      SEC_GREEN: sec_off = 3'(HUE_OFF_GREEN);
      SEC_BLUE:  sec_off = 3'(HUE_OFF_BLUE);
      default:   sec_off = 3'd0;
    endcase

    sec_base = 11'(sec_off) * 11'(s1_d_r);
    hue_k_s  = $signed({1'b0, sec_base}) + {{3{s1_diff_r[COMP_W]}}, s1_diff_r};
    hue_k    = hue_k_s[10:0];

    // 3840 * k as 4096 * k - 256 * k.
    hue_num = DIV_NUM_W'({hue_k, 12'b0}) - DIV_NUM_W'({hue_k, 8'b0});
    // 65535 * d as 65536 * d - d.
    sat_num = DIV_NUM_W'({s1_d_r, 16'b0}) - DIV_NUM_W'(s1_d_r);

    if (gray) begin
      hue_den = DIV_DEN_W'(1);
      sat_den = DIV_DEN_W'(1);
    end else begin
      hue_den = s1_d_r;
      if (s1_sum_r < (COMP_W + 1)'(SUM_HALF)) begin
        sat_den = s1_sum_r[DIV_DEN_W-1:0];
      end else begin
        sat_den = DIV_DEN_W'((COMP_W + 1)'(SUM_FULL) - s1_sum_r);
      end
    end

    lit_x2 = (FRAC_W + 1)'({s1_sum_r, 8'b0}) + (FRAC_W + 1)'(s1_sum_r)
           + (FRAC_W + 1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_gray_r    <= gray;
    s2_hue_num_r <= hue_num;
    s2_sat_num_r <= sat_num;
    s2_hue_den_r <= hue_den;
    s2_sat_den_r <= sat_den;
    s2_lit_r     <= lit_x2[FRAC_W:1];
  end

  // ---------------------------------------------------------------------------
  // Dividers: two identical bit-per-stage pipelines run side by side, so the
  // hue and saturation quotients come out on the same cycle.
  // ---------------------------------------------------------------------------
  logic [DIV_Q_W-1:0] hue_q;
  logic [DIV_Q_W-1:0] sat_q;

  rgbhsl_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W),
    .Q_W   (DIV_Q_W)
  ) u_hue_div (
    .clk  (clk),
    .num  (s2_hue_num_r),
    .den  (s2_hue_den_r),
    .quot (hue_q)
  );

  rgbhsl_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W),
    .Q_W   (DIV_Q_W)
  ) u_sat_div (
    .clk  (clk),
    .num  (s2_sat_num_r),
    .den  (s2_sat_den_r),
    .quot (sat_q)
  );

  // Valid, gray flag and lightness ride a delay line that matches the
  // divider latency.
  logic              dly_valid_r [0:DIV_LAT-1];
  logic              dly_gray_r  [0:DIV_LAT-1];
  logic [FRAC_W-1:0] dly_lit_r   [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < DIV_LAT; j++) begin
        dly_valid_r[j] <= 1'b0;
      end
    end else begin
      dly_valid_r[0] <= s2_valid_r;
      for (int j = 1; j < DIV_LAT; j++) begin
        dly_valid_r[j] <= dly_valid_r[j-1];
      end
    end
    dly_gray_r[0] <= s2_gray_r;
    dly_lit_r[0]  <= s2_lit_r;
    for (int j = 1; j < DIV_LAT; j++) begin
      dly_gray_r[j] <= dly_gray_r[j-1];
      dly_lit_r[j]  <= dly_lit_r[j-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: the result strobe is high for exactly one cycle per
  // request. Gray pixels report zero hue and zero saturation.
  // ---------------------------------------------------------------------------
  logic       out_valid_r;
  hsl_pixel_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dly_valid_r[DIV_LAT-1];
    end
    out_data_r.hue        <= dly_gray_r[DIV_LAT-1] ? '0 : hue_q[HUE_W-1:0];
    out_data_r.saturation <= dly_gray_r[DIV_LAT-1] ? '0 : sat_q[FRAC_W-1:0];
    out_data_r.lightness  <= dly_lit_r[DIV_LAT-1];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // Every result strobe traces back to a request taken earlier.
  a_strobe_has_request: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, PIPE_LAT)
  ) else $error("result strobe without a matching request");

  // The hue divider never produces a full turn or more.
  a_hue_in_range: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.hue < HUE_W'(HUE_FULL_TURN))
  ) else $error("hue out of range");

  // Black is gray, so zero lightness must come with zero hue and saturation.
  a_black_is_gray: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.lightness == '0)
      |-> (out_data.hue == '0 && out_data.saturation == '0)
  ) else $error("black pixel with nonzero hue or saturation");

endmodule

`default_nettype wire

// File: sim/rgb_to_hsl_checker.sv
// Scoreboard for the RGB to HSL converter: watches the request and result
// channels, predicts each result in fixed point and compares field by field.
// Depends on rgbhsl_pkg for the pixel structs.
`timescale 1ns / 1ps

module rgb_to_hsl_checker import rgbhsl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  rgb_pixel_t in_data,
  input  logic       out_valid,
  input  hsl_pixel_t out_data,
  output int         mismatch_count,
  output int         pending_count,
  output int         request_count,
  output int         result_count
);

  hsl_pixel_t hsl_expected_q[$];
  int         n_mismatch = 0;
  int         n_request  = 0;
  int         n_result   = 0;

  // Nearest-integer quotient, an exact half goes up.
  function automatic longint unsigned div_nearest(input longint unsigned num,
                                                  input longint unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic hsl_pixel_t predict_hsl(input rgb_pixel_t px);
    longint unsigned r, g, b, mx, mn, sum, d, den, num;
    hsl_pixel_t      hsl;
    r = px.red;
    g = px.green;
    b = px.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    sum = mx + mn;
    d   = mx - mn;
    hsl.lightness  = FRAC_W'(div_nearest(sum * 65535, 510));
    hsl.hue        = '0;
    hsl.saturation = '0;
    if (d != 0) begin
      den = (sum < SUM_HALF) ? sum : (SUM_FULL - sum);
      hsl.saturation = FRAC_W'(div_nearest(d * 65535, den));
      // Ties for the maximum go to red first, then green.
      if (mx == r) begin
        if (g >= b) num = 3840 * (g - b);
        else        num = HUE_FULL_TURN * d - 3840 * (b - g);
      end else if (mx == g) begin
        num = 7680 * d + 3840 * b - 3840 * r;
      end else begin
        num = 15360 * d + 3840 * r - 3840 * g;
      end
      hsl.hue = HUE_W'(div_nearest(num, d));
    end
    return hsl;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      n_mismatch++;
    end
  endfunction

  always @(posedge clk) begin
    hsl_pixel_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (hsl_expected_q.size() == 0) begin
          $error("result strobe with no request outstanding");
          n_mismatch++;
        end else begin
          want = hsl_expected_q.pop_front();
          check_field("hue", int'(want.hue), int'(out_data.hue));
          check_field("saturation", int'(want.saturation), int'(out_data.saturation));
          check_field("lightness", int'(want.lightness), int'(out_data.lightness));
          n_result++;
        end
      end
      if (start && !busy) begin
        hsl_expected_q.push_back(predict_hsl(in_data));
        n_request++;
      end
    end
    mismatch_count <= n_mismatch;
    pending_count  <= hsl_expected_q.size();
    request_count  <= n_request;
    result_count   <= n_result;
  end

endmodule

// File: sim/rgb_to_hsl_converter_tb.sv
// Top of the RGB to HSL converter testbench: clock, reset, pixel stimulus and
// the final verdict. Depends on rgbhsl_pkg, the converter and rgb_to_hsl_checker.
`timescale 1ns / 1ps

module rgb_to_hsl_converter_tb;
  import rgbhsl_pkg::*;

  localparam int RANDOM_PIXELS = 1050;
  // Divider latency plus some margin for the final drain.
  localparam int DRAIN_CYCLES  = DIV_LAT + 8;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  rgb_pixel_t in_data;
  logic       out_valid;
  hsl_pixel_t out_data;

  int mismatch_count;
  int pending_count;
  int request_count;
  int result_count;

  // When set, the sender inserts a random gap before each request; when clear,
  // requests go back to back.
  bit gaps_on;

  rgb_to_hsl_converter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  rgb_to_hsl_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .request_count  (request_count),
    .result_count   (result_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: the slowest legal run is far below this.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Issues one pixel request. Inputs move only on the falling edge, and the
  // request is taken at the first rising edge where busy is low. Start stays
  // high across back-to-back requests, so it is never lowered and raised in
  // the same time step.
  task automatic send_pixel(input rgb_pixel_t px);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (busy);
  endtask

  // Holds the sender off until every outstanding request has its result.
  task automatic drain_pipeline();
    @(negedge clk);
    start <= 1'b0;
    wait (pending_count == 0);
  endtask

  // Components near the ends of the range, or anything at all.
  function automatic logic [COMP_W-1:0] extreme_component();
    case ($urandom_range(0, 4))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd254;
      3:       return 8'd255;
      default: return COMP_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly uniform colors, with a share of gray levels, ties for the maximum
  // and near-extreme components, since those steer the sector and divisor choice.
  function automatic rgb_pixel_t random_pixel();
    rgb_pixel_t        px;
    int unsigned       pick;
    logic [COMP_W-1:0] top, other;
    pick     = $urandom_range(0, 99);
    px.red   = COMP_W'($urandom_range(0, 255));
    px.green = COMP_W'($urandom_range(0, 255));
    px.blue  = COMP_W'($urandom_range(0, 255));
    if (pick < 12) begin
      px.green = px.red;
      px.blue  = px.red;
    end else if (pick < 26) begin
      top   = COMP_W'($urandom_range(0, 255));
      other = COMP_W'($urandom_range(0, top));
      case (pick % 3)
        0:       px = {top, top, other};
        1:       px = {other, top, top};
        default: px = {top, other, top};
      endcase
    end else if (pick < 40) begin
      px.red   = extreme_component();
      px.green = extreme_component();
      px.blue  = extreme_component();
    end
    return px;
  endfunction

  initial begin
    bit errors_seen;
    start   = 1'b0;
    in_data = '0;
    rst_n   = 1'b0;
    gaps_on = 1'b1;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed corners: black, white and gray, the primaries, the two-way
    // ties, hue just above zero and just below a full turn, and sums on
    // either side of the point where the saturation divisor switches.
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h808080);
    send_pixel(24'h010101);
    send_pixel(24'hFF0000);
    send_pixel(24'h00FF00);
    send_pixel(24'h0000FF);
    send_pixel(24'hFFFF00);
    send_pixel(24'h00FFFF);
    send_pixel(24'hFF00FF);
    send_pixel(24'hFF0001);
    send_pixel(24'hFF0100);
    send_pixel(24'hC83764);
    send_pixel(24'hC83664);
    send_pixel(24'hC83864);
    send_pixel(24'h3CC80A);
    send_pixel(24'h0A3CC8);
    send_pixel(24'hC80A3C);
    send_pixel(24'h7F8080);
    send_pixel(24'h010000);
    send_pixel(24'hFEFFFF);
    send_pixel(24'h00FF80);
    send_pixel(24'h8000FF);
    send_pixel(24'h55AA00);

    // Let the pipeline empty completely once before the random part.
    drain_pipeline();

    // Random part in chunks, each with gaps either on or off, so that both
    // sparse and back-to-back traffic hit every pipeline stage.
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      if (i == RANDOM_PIXELS / 2) drain_pipeline();
      send_pixel(random_pixel());
    end

    @(negedge clk);
    start <= 1'b0;
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    errors_seen = (mismatch_count != 0) || (pending_count != 0);
    $display("Summary: %0d pixel requests, %0d results compared (corners, ties, grays, %s",
             request_count, result_count, "saturation boundary, random colors).");
    if (!errors_seen) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
